// ===== rtl/mwst_pkg.sv =====
// Shared types and constants of the maximum window sum tracker.
`default_nettype none

package mwst_pkg;

  // Window sums are kept modulo 2^SUM_WIDTH and compared as signed values.
  localparam int SUM_WIDTH = 24;
  // Width of the window length register word.
  localparam int CFG_WIDTH = 9;

  typedef logic signed [SUM_WIDTH-1:0] sum_t;
  typedef logic [CFG_WIDTH-1:0] cfg_word_t;

endpackage

`default_nettype wire

// ===== rtl/mwst_ifs.sv =====
// Valid/ready channel interfaces of the maximum window sum tracker.
`default_nettype none

interface mwst_cfg_if
  import mwst_pkg::*;
  ();
  logic      valid;
  logic      ready;
  cfg_word_t window_length;

  modport source (output valid, output window_length, input ready);
  modport sink (input valid, input window_length, output ready);
endinterface

interface mwst_in_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface mwst_out_if
  import mwst_pkg::*;
  #(
  parameter int POSITION_WIDTH = 16
) ();
  logic                      valid;
  logic                      ready;
  sum_t                      window_sum;
  logic                      window_full;
  sum_t                      best_sum;
  logic [POSITION_WIDTH-1:0] best_start;
  logic [POSITION_WIDTH-1:0] best_end;
  logic                      best_valid;
  logic                      stream_done;
  logic                      length_overflow;

  modport source (
    output valid, output window_sum, output window_full, output best_sum,
    output best_start, output best_end, output best_valid, output stream_done,
    output length_overflow, input ready
  );
  modport sink (
    input valid, input window_sum, input window_full, input best_sum,
    input best_start, input best_end, input best_valid, input stream_done,
    input length_overflow, output ready
  );
endinterface

`default_nettype wire

// ===== rtl/max_window_sum_tracker_top.sv =====
// Top level of the maximum window sum tracker.
`default_nettype none

// Maximum-sum sliding window tracker. Takes one signed sample word per cycle
// on the samples channel, sustained, and returns one result word per sample on
// the results channel. The result word passes through the stage-1 register
// and then the output register. The delay-line memory read happens at the
// accepting edge, beside the stage-1 register. The sum update and best
// compare land in the output register. A result word that is not taken holds
// stage 1, and then the input. The window length (0 acts as 1, values above
// WINDOW_MAX act as WINDOW_MAX) is written through the cfg channel, which is
// always ready; a write restarts the stream and must only be issued while the
// block is empty. The delay line is a WINDOW_MAX-entry read-first RAM used as
// a circular buffer of length window_length: each sample reads the entry it
// overwrites, which is exactly the sample leaving the window, so no bypass is
// needed. No clearing pass is run; entries are only read after being written
// in the current stream. Ties keep the earliest window; best fields read zero
// until the first full window. Positions past 2^POSITION_WIDTH-1 set
// length_overflow and a best end recorded then saturates. All stream state
// clears after the word flagged last_sample is processed.
module max_window_sum_tracker_top
  import mwst_pkg::*;
  #(
  parameter int WINDOW_MAX     = 256,
  parameter int SAMPLE_WIDTH   = 16,
  parameter int POSITION_WIDTH = 16
) (
  input wire logic clk,
  input wire logic rst,
  mwst_cfg_if.sink cfg,
  mwst_in_if.sink  samples,
  mwst_out_if.source results
);

  // Window length and memory address widths.
  localparam int KW = $clog2(WINDOW_MAX + 1);
  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int PW = POSITION_WIDTH;
  // Position counter: wide enough to pass both the position limit and WINDOW_MAX.
  localparam int CW = ((PW + 1) > KW) ? (PW + 1) : KW;
  localparam logic [CW-1:0] POS_LIMIT = CW'(1) << PW;

  // ---------------- configuration ----------------
  logic [KW-1:0] k_len;
  logic [KW-1:0] k_minus1;
  logic [KW-1:0] k_cfg;
  logic          cfg_wr;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid;

  always_comb begin
    if (cfg.window_length == '0) begin
      k_cfg = KW'(1);
    end else if (32'(cfg.window_length) > 32'(WINDOW_MAX)) begin
      k_cfg = KW'(WINDOW_MAX);
    end else begin
      k_cfg = KW'(cfg.window_length);
    end
  end

  // ---------------- handshake ----------------
  logic s1_valid;
  logic adv;   // stage 1 moves into the output register
  logic acc;   // sample word accepted

  assign adv           = s1_valid && (!results.valid || results.ready);
  assign samples.ready = !s1_valid || adv;
  assign acc           = samples.valid && samples.ready;

  // ---------------- stage 1: address, position ----------------
  logic [AW-1:0] wr_ptr;
  logic [CW-1:0] pos_count;

  logic signed [SAMPLE_WIDTH-1:0] s1_sample;
  logic          s1_last;
  logic          s1_sub;     // oldest sample leaves the window
  logic          s1_full;
  logic          s1_ovf;
  logic [PW-1:0] s1_pos;
  logic [PW-1:0] s1_start;

  logic          pos_ovf;
  logic [PW-1:0] pos_clamp;
  logic [KW-1:0] ptr_inc;

  assign pos_ovf   = pos_count >= POS_LIMIT;
  assign pos_clamp = pos_ovf ? {PW{1'b1}} : pos_count[PW-1:0];
  assign ptr_inc   = KW'(wr_ptr) + KW'(1);

  logic [SAMPLE_WIDTH-1:0] old_sample;

  mwst_delay_line #(
    .DEPTH (WINDOW_MAX),
    .AW    (AW),
    .DW    (SAMPLE_WIDTH)
  ) u_delay (
    .clk   (clk),
    .en    (acc),
    .addr  (wr_ptr),
    .wdata (samples.sample),
    .rdata (old_sample)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      pos_count <= '0;
      k_len     <= KW'(1);
      k_minus1  <= '0;
    end else if (cfg_wr) begin
      wr_ptr    <= '0;
      pos_count <= '0;
      k_len     <= k_cfg;
      k_minus1  <= k_cfg - KW'(1);
    end else if (acc) begin
      if (samples.last_sample) begin
        wr_ptr    <= '0;
        pos_count <= '0;
      end else begin
        wr_ptr    <= (ptr_inc >= k_len) ? '0 : AW'(ptr_inc);
        pos_count <= (&pos_count) ? pos_count : pos_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_sample <= samples.sample;
      s1_last   <= samples.last_sample;
      s1_sub    <= pos_count >= CW'(k_len);
      s1_full   <= pos_count >= CW'(k_minus1);
      s1_ovf    <= pos_ovf;
      s1_pos    <= pos_clamp;
      s1_start  <= pos_clamp - PW'(k_minus1);
    end
  end

  // ---------------- stage 2: sum update, best tracking ----------------
  sum_t          running_sum;
  sum_t          best_value;
  logic [PW-1:0] best_end_pos;
  logic [PW-1:0] best_start_pos;
  logic          best_seen;
  logic          overflow_seen;

  sum_t          sum_next;
  sum_t          leave;
  logic          take;
  sum_t          best_value_next;
  logic [PW-1:0] best_end_next;
  logic [PW-1:0] best_start_next;
  logic          best_seen_next;
  logic          overflow_next;

  assign leave    = s1_sub ? SUM_WIDTH'($signed(old_sample)) : '0;
  assign sum_next = running_sum + SUM_WIDTH'(s1_sample) - leave;
  // First full window always wins; later ones only when strictly larger.
  assign take     = s1_full && (!best_seen || (sum_next > best_value));

  assign best_value_next = take ? sum_next : best_value;
  assign best_end_next   = take ? s1_pos : best_end_pos;
  assign best_start_next = take ? s1_start : best_start_pos;
  assign best_seen_next  = best_seen || take;
  assign overflow_next   = overflow_seen || s1_ovf;

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      running_sum    <= '0;
      best_value     <= '0;
      best_end_pos   <= '0;
      best_start_pos <= '0;
      best_seen      <= 1'b0;
      overflow_seen  <= 1'b0;
    end else if (adv) begin
      if (s1_last) begin
        running_sum    <= '0;
        best_value     <= '0;
        best_end_pos   <= '0;
        best_start_pos <= '0;
        best_seen      <= 1'b0;
        overflow_seen  <= 1'b0;
      end else begin
        running_sum    <= sum_next;
        best_value     <= best_value_next;
        best_end_pos   <= best_end_next;
        best_start_pos <= best_start_next;
        best_seen      <= best_seen_next;
        overflow_seen  <= overflow_next;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (adv) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      results.window_sum      <= s1_full ? sum_next : '0;
      results.window_full     <= s1_full;
      results.best_sum        <= best_value_next;
      results.best_start      <= best_start_next;
      results.best_end        <= best_end_next;
      results.best_valid      <= best_seen_next;
      results.stream_done     <= s1_last;
      results.length_overflow <= overflow_next;
    end
  end

`ifndef SYNTHESIS
  // Circular write pointer stays inside the current window.
  a_ptr_in_window: assert property (@(posedge clk) disable iff (rst)
    KW'(wr_ptr) < k_len)
    else $error("write pointer outside window");

  // A held stage-1 word is never overwritten by a new sample.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |-> !acc)
    else $error("stage 1 overrun");

  // A full window always yields a valid best.
  a_full_has_best: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.window_full |-> results.best_valid)
    else $error("full window without best");

  // The last sample of a stream restarts the position count.
  a_last_clears_pos: assert property (@(posedge clk) disable iff (rst)
    acc && samples.last_sample |=> pos_count == '0)
    else $error("position count not cleared after last sample");
`endif

endmodule

`default_nettype wire

// ===== rtl/mwst_delay_line.sv =====
// Single-port read-first sample memory for the window delay line.
`default_nettype none

module mwst_delay_line #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 16
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [AW-1:0] addr,
  input  wire logic [DW-1:0] wdata,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Read returns the entry as it was before this cycle's write.
  always_ff @(posedge clk) begin
    if (en) begin
      rdata      <= mem[addr];
      mem[addr]  <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/mwst_window_checker.sv =====
// Checker for the window sum tracker: predicts each result word and compares it.
`timescale 1ns / 100ps

module mwst_window_checker
  import mwst_pkg::*;
  (
  input  logic       clk,
  input  logic       rst,
  mwst_cfg_if        cfg,
  mwst_in_if         samples,
  mwst_out_if        results,
  output int         fail_count,
  output int         outstanding,
  output int         checked
);

  localparam int DEPTH     = 256;
  localparam int POS_LIMIT = 65536;

  typedef struct packed {
    sum_t        window_sum;
    logic        window_full;
    sum_t        best_sum;
    logic [15:0] best_start;
    logic [15:0] best_end;
    logic        best_valid;
    logic        stream_done;
    logic        length_overflow;
  } window_result_t;

  // Predicted block state.
  logic signed [15:0]   tap_line [DEPTH];
  logic [SUM_WIDTH-1:0] acc_sum;
  longint               sample_pos;
  sum_t                 peak_sum;
  logic [15:0]          peak_end;
  logic                 peak_seen;
  logic                 pos_overflow;
  int                   tap_ptr;
  cfg_word_t            win_len;

  window_result_t pending_windows[$];
  int errors;
  int matched;

  initial begin
    errors  = 0;
    matched = 0;
  end

  function automatic int active_length();
    if (win_len == '0) return 1;
    if (win_len > DEPTH) return DEPTH;
    return int'(win_len);
  endfunction

  task automatic restart_stream();
    acc_sum      = '0;
    sample_pos   = 0;
    peak_sum     = '0;
    peak_end     = '0;
    peak_seen    = 1'b0;
    pos_overflow = 1'b0;
    tap_ptr      = 0;
  endtask

  task automatic predict_window_step(input logic signed [15:0] s, input logic last,
                                     output window_result_t r);
    int     k;
    int     wp;
    longint pos;
    logic   full;
    sum_t   cur;
    k  = active_length();
    wp = (tap_ptr >= k) ? 0 : tap_ptr;
    pos = sample_pos;
    if (pos >= POS_LIMIT) begin
      pos_overflow = 1'b1;
      pos = POS_LIMIT - 1;
    end
    // add the new sample, drop the one leaving the window
    acc_sum = acc_sum + {{(SUM_WIDTH-16){s[15]}}, s};
    if (sample_pos >= k)
      acc_sum = acc_sum - {{(SUM_WIDTH-16){tap_line[wp][15]}}, tap_line[wp]};
    tap_line[wp] = s;
    tap_ptr = (wp + 1 >= k) ? 0 : wp + 1;
    full = (sample_pos + 1 >= k);
    if (full) begin
      cur = sum_t'(acc_sum);
      // strict compare: ties keep the earliest window
      if (!peak_seen || cur > peak_sum) begin
        peak_sum  = cur;
        peak_end  = 16'(pos);
        peak_seen = 1'b1;
      end
    end
    sample_pos++;
    r = '0;
    if (full) begin
      r.window_sum  = sum_t'(acc_sum);
      r.window_full = 1'b1;
    end
    if (peak_seen) begin
      r.best_sum   = peak_sum;
      r.best_start = peak_end - 16'(k - 1);
      r.best_end   = peak_end;
      r.best_valid = 1'b1;
    end
    r.stream_done     = last;
    r.length_overflow = pos_overflow;
    if (last) restart_stream();
  endtask

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    window_result_t got;
    window_result_t want;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) tap_line[i] = '0;
      win_len = cfg_word_t'(1);
      restart_stream();
      pending_windows.delete();
    end else begin
      if (results.valid && results.ready) begin
        got.window_sum      = results.window_sum;
        got.window_full     = results.window_full;
        got.best_sum        = results.best_sum;
        got.best_start      = results.best_start;
        got.best_end        = results.best_end;
        got.best_valid      = results.best_valid;
        got.stream_done     = results.stream_done;
        got.length_overflow = results.length_overflow;
        if (pending_windows.size() == 0) begin
          errors++;
          $display("%0t ns: result word with none expected, expected none, actual %h",
                   $time, got);
        end else begin
          want = pending_windows.pop_front();
          check_field("window_sum", $signed(want.window_sum), $signed(got.window_sum));
          check_field("window_full", want.window_full, got.window_full);
          check_field("best_sum", $signed(want.best_sum), $signed(got.best_sum));
          check_field("best_start", want.best_start, got.best_start);
          check_field("best_end", want.best_end, got.best_end);
          check_field("best_valid", want.best_valid, got.best_valid);
          check_field("stream_done", want.stream_done, got.stream_done);
          check_field("length_overflow", want.length_overflow, got.length_overflow);
          matched++;
        end
      end
      if (cfg.valid && cfg.ready) begin
        win_len = cfg.window_length;
        restart_stream();
      end
      if (samples.valid && samples.ready) begin
        predict_window_step(samples.sample, samples.last_sample, want);
        pending_windows.push_back(want);
      end
    end
    fail_count  <= errors;
    outstanding <= pending_windows.size();
    checked     <= matched;
  end

endmodule

// ===== tb/sv/max_window_sum_tracker_top_test.sv =====
// Top of the window sum tracker testbench: stimulus, pacing and verdict.
`timescale 1ns / 100ps

module max_window_sum_tracker_top_test;
  import mwst_pkg::*;

  localparam int DEPTH     = 256;
  localparam int RANDOM_ITEMS = 250;

  // How the samples of one stream are drawn.
  typedef enum int {
    MIX_RANDOM, MIX_MAX, MIX_MIN, MIX_SMALL, MIX_FLAT, MIX_SPIKY
  } sample_mix_e;

  // Idle pattern of sender and receiver.
  typedef enum int {
    PACE_SENDER_LIGHT, PACE_RECEIVER_LIGHT, PACE_NONE
  } pacing_e;

  logic clk = 1'b0;
  logic rst;

  int tx_idle = 15;
  int rx_idle = 62;

  int fail_count;
  int outstanding;
  int checked;

  int random_items = 0;
  int streams_closed = 0;
  int cfg_writes = 0;

  mwst_cfg_if                        cfg_ch ();
  mwst_in_if  #(.SAMPLE_WIDTH(16))   sample_ch ();
  mwst_out_if #(.POSITION_WIDTH(16)) result_ch ();

  max_window_sum_tracker_top #(
    .WINDOW_MAX     (DEPTH),
    .SAMPLE_WIDTH   (16),
    .POSITION_WIDTH (16)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .samples (sample_ch),
    .results (result_ch)
  );

  mwst_window_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_ch),
    .samples     (sample_ch),
    .results     (result_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .checked     (checked)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(10_000_000);
    $display("tb: failure");
    $finish;
  end

  // Receiver: ready changes on the falling edge, idling per the current pace.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ch.ready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  function automatic int eff_length(input cfg_word_t v);
    if (v == '0) return 1;
    if (v > DEPTH) return DEPTH;
    return int'(v);
  endfunction

  task automatic set_pacing(input pacing_e p);
    case (p)
      PACE_SENDER_LIGHT: begin
        tx_idle = 15;
        rx_idle = 62;
      end
      PACE_RECEIVER_LIGHT: begin
        tx_idle = 62;
        rx_idle = 15;
      end
      default: begin
        tx_idle = 0;
        rx_idle = 0;
      end
    endcase
  endtask

  // Present one sample word; entered and left just after a falling edge.
  // Random idle cycles go in front, so gaps land anywhere in a stream.
  task automatic send_word(input logic signed [15:0] s, input logic last);
    while ($urandom_range(0, 99) < tx_idle) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.sample      <= s;
    sample_ch.last_sample <= last;
    do @(posedge clk); while (!sample_ch.ready);
    @(negedge clk);
    if (last) streams_closed++;
  endtask

  // The register may only change with the pipe empty: stop sending, wait for
  // every result word, let the two-stage pipe settle, then write.
  task automatic write_window_length(input cfg_word_t v);
    sample_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.window_length <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    cfg_writes++;
  endtask

  // One stream of len samples; close marks the final one as last.
  task automatic run_stream(input int len, input sample_mix_e mix, input bit close);
    logic signed [15:0] flat;
    logic signed [15:0] s;
    flat = 16'($urandom());
    for (int i = 0; i < len; i++) begin
      case (mix)
        MIX_MAX:   s = 16'sh7fff;
        MIX_MIN:   s = 16'sh8000;
        MIX_SMALL: s = 16'($urandom_range(0, 16)) - 16'sd8;
        MIX_FLAT:  s = flat;
        MIX_SPIKY: begin
          if ($urandom_range(0, 7) == 0)
            s = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          else
            s = 16'($urandom_range(0, 200)) - 16'sd100;
        end
        default:   s = 16'($urandom());
      endcase
      send_word(s, close && (i == len - 1));
    end
    random_items += len;
  endtask

  initial begin
    cfg_word_t wl;
    int        k;
    int        n_streams;
    int        len;
    int        pick;
    int        guard;
    bit        close;

    rst                   = 1'b1;
    cfg_ch.valid          = 1'b0;
    cfg_ch.window_length  = '0;
    sample_ch.valid       = 1'b0;
    sample_ch.sample      = '0;
    sample_ch.last_sample = 1'b0;
    set_pacing(PACE_SENDER_LIGHT);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // Reset length of one: every sample is its own window, full extremes.
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sd0, 1'b0);
    send_word(-16'sd1, 1'b0);
    send_word(16'sd1, 1'b1);

    // Zero acts as one; equal sums keep the first window.
    write_window_length(cfg_word_t'(0));
    send_word(16'sd5, 1'b0);
    send_word(16'sd5, 1'b1);

    // Stream shorter than the window: best stays invalid through last.
    write_window_length(cfg_word_t'(3));
    send_word(16'sd100, 1'b0);
    send_word(16'sd200, 1'b1);
    // Ties on a flat run, then a strictly larger window later on.
    send_word(-16'sd5, 1'b0);
    send_word(-16'sd5, 1'b0);
    send_word(-16'sd5, 1'b0);
    send_word(-16'sd5, 1'b0);
    send_word(16'sd7, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh7fff, 1'b1);

    // Largest legal length, and one above it that saturates.
    write_window_length(cfg_word_t'(DEPTH));
    send_word(16'sh7fff, 1'b0);
    send_word(16'sd1, 1'b1);
    write_window_length(cfg_word_t'(DEPTH + 1));
    send_word(-16'sd1, 1'b1);

    // A write in the middle of an open stream restarts it.
    write_window_length(cfg_word_t'(4));
    send_word(16'sd1, 1'b0);
    send_word(16'sd2, 1'b0);
    send_word(16'sd3, 1'b0);
    write_window_length(cfg_word_t'(2));
    send_word(16'sd9, 1'b0);
    send_word(16'sd9, 1'b0);
    send_word(-16'sd9, 1'b1);

    // ---- random part ----
    // Mostly well-formed streams long enough to fill the window; some short
    // ones, and some left open when the next length is written.
    while (random_items < RANDOM_ITEMS) begin
      if (random_items >= (2 * RANDOM_ITEMS) / 3)
        set_pacing(PACE_NONE);
      else if (random_items >= RANDOM_ITEMS / 3)
        set_pacing(PACE_RECEIVER_LIGHT);

      pick = $urandom_range(0, 99);
      if (pick < 70)
        wl = cfg_word_t'($urandom_range(1, 12));
      else if (pick < 80)
        wl = '0;
      else if (pick < 90)
        wl = cfg_word_t'($urandom_range(13, 40));
      else
        wl = cfg_word_t'($urandom_range(DEPTH + 1, 511));
      write_window_length(wl);
      k = eff_length(wl);

      n_streams = $urandom_range(1, 4);
      for (int j = 0; j < n_streams; j++) begin
        pick = $urandom_range(0, 99);
        if (k > 40)
          len = $urandom_range(1, 40);        // big windows: keep it cheap
        else if (pick < 75)
          len = $urandom_range(k, 3 * k + 8);
        else if (pick < 90)
          len = $urandom_range(1, k);
        else
          len = $urandom_range(1, 6);
        close = (j < n_streams - 1) || ($urandom_range(0, 3) != 0);
        run_stream(len, sample_mix_e'($urandom_range(0, 5)), close);
      end
    end

    // ---- full-length windows at the sum extremes ----
    set_pacing(PACE_NONE);
    write_window_length(cfg_word_t'(DEPTH));
    run_stream(DEPTH + 4, MIX_MAX, 1'b1);
    run_stream(DEPTH + 4, MIX_MIN, 1'b1);

    // ---- drain ----
    sample_ch.valid <= 1'b0;
    for (guard = 0; guard < 20000 && outstanding != 0; guard++) @(negedge clk);
    repeat (8) @(negedge clk);

    if (outstanding != 0)
      $display("%0t ns: %0d result words never arrived", $time, outstanding);
    $display("summary: %0d result words checked, %0d closed streams, %0d length writes",
             checked, streams_closed, cfg_writes);
    $display("summary: lengths 0..511, sum extremes, ties, short streams, restarts");
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== max_window_sum_tracker_top.f =====
rtl/mwst_pkg.sv
rtl/mwst_ifs.sv
rtl/mwst_delay_line.sv
rtl/max_window_sum_tracker_top.sv
tb/sv/mwst_window_checker.sv
tb/sv/max_window_sum_tracker_top_test.sv
